// File: rtl/core/tbcs_pkg.sv
// Package for the triangle bounding-box coverage scan.
// Holds field widths, status, op and register codes, and the rounding helper.
// No dependencies.
`default_nettype none
package tbcs_pkg;

   localparam int MAX_SCREEN_DEF = 1024;
   localparam int FRAC_BITS_DEF  = 3;

   localparam int VERT_W  = 14;
   localparam int EDGE_W  = 15;
   localparam int RND_W   = 16;
   localparam int CSR_W   = 11;
   localparam int DOT_W   = 31;
   localparam int DEN_W   = 62;
   localparam int OPA_W   = 36;
   localparam int OPB_W   = 32;
   localparam int ACC_W   = 70;
   localparam int STEP_W  = 4;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam logic [1:0] ST_PIXEL     = 2'd0;
   localparam logic [1:0] ST_ACCEPT    = 2'd1;
   localparam logic [1:0] ST_REJECT    = 2'd2;
   localparam logic [1:0] ST_IDLE_STEP = 2'd3;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic                    clr;
      logic                    sub;
      logic signed [OPA_W-1:0] a;
      logic signed [OPB_W-1:0] b;
   } mac_op_type;

   // round half away from zero to whole pixels
   function automatic logic signed [RND_W-1:0] round_px(
      input logic signed [VERT_W-1:0] v, input int frac);
      logic [RND_W-1:0] mag;
      logic [RND_W-1:0] half;
      logic [RND_W-1:0] r;
      mag  = v[VERT_W-1] ? RND_W'(-RND_W'(v)) : RND_W'(v);
      half = RND_W'((1 << frac) >> 1);
      r    = (mag + half) >> frac;
      return v[VERT_W-1] ? $signed(-r) : $signed(r);
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/tbcs_mac.sv
// Shared multiply-accumulate unit for setup and per-pixel tests.
// Depends on tbcs_pkg.
`default_nettype none
module tbcs_mac (
   input  wire                                 clock,
   input  wire                                 en,
   input  wire tbcs_pkg::mac_op_type           op,
   output logic signed [tbcs_pkg::ACC_W-1:0]   sum
);
   import tbcs_pkg::*;

   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] prod;
   logic signed [ACC_W-1:0] base;

   always_comb begin
      prod = ACC_W'(op.a * op.b);
      base = op.clr ? '0 : acc_ff;
      sum  = op.sub ? base - prod : base + prod;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= sum;
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/tbcs_box.sv
// Bounding box of a triangle: rounding, min/max and screen clamp.
// Depends on tbcs_pkg.
`default_nettype none
module tbcs_box #(
   parameter int MAX_SCREEN = tbcs_pkg::MAX_SCREEN_DEF,
   parameter int FRAC_BITS  = tbcs_pkg::FRAC_BITS_DEF,
   localparam int SW        = $clog2(MAX_SCREEN + 1)
) (
   input  wire signed [tbcs_pkg::VERT_W-1:0] vx0,
   input  wire signed [tbcs_pkg::VERT_W-1:0] vy0,
   input  wire signed [tbcs_pkg::VERT_W-1:0] vx1,
   input  wire signed [tbcs_pkg::VERT_W-1:0] vy1,
   input  wire signed [tbcs_pkg::VERT_W-1:0] vx2,
   input  wire signed [tbcs_pkg::VERT_W-1:0] vy2,
   input  wire        [tbcs_pkg::CSR_W-1:0]  scr_w,
   input  wire        [tbcs_pkg::CSR_W-1:0]  scr_h,
   output logic       [SW-1:0]               left,
   output logic       [SW-1:0]               top,
   output logic       [SW-1:0]               right,
   output logic       [SW-1:0]               bottom,
   output logic                              empty
);
   import tbcs_pkg::*;

   localparam int CW = RND_W + 2;

   logic signed [RND_W-1:0] rx0, rx1, rx2, ry0, ry1, ry2;
   logic signed [RND_W-1:0] mnx, mxx, mny, mxy;
   logic signed [CW-1:0]    ws, hs, l_s, t_s, r_s, b_s;

   always_comb begin
      rx0 = round_px(vx0, FRAC_BITS);
      rx1 = round_px(vx1, FRAC_BITS);
      rx2 = round_px(vx2, FRAC_BITS);
      ry0 = round_px(vy0, FRAC_BITS);
      ry1 = round_px(vy1, FRAC_BITS);
      ry2 = round_px(vy2, FRAC_BITS);
      mnx = rx0; mxx = rx0; mny = ry0; mxy = ry0;
      if (rx1 < mnx) mnx = rx1;
      if (rx2 < mnx) mnx = rx2;
      if (rx1 > mxx) mxx = rx1;
      if (rx2 > mxx) mxx = rx2;
      if (ry1 < mny) mny = ry1;
      if (ry2 < mny) mny = ry2;
      if (ry1 > mxy) mxy = ry1;
      if (ry2 > mxy) mxy = ry2;
      ws = (CW'(scr_w) > CW'(MAX_SCREEN)) ? CW'(MAX_SCREEN) : CW'(scr_w);
      hs = (CW'(scr_h) > CW'(MAX_SCREEN)) ? CW'(MAX_SCREEN) : CW'(scr_h);
      l_s = (mnx < 0) ? '0 : CW'(mnx);
      t_s = (mny < 0) ? '0 : CW'(mny);
      r_s = CW'(mxx) + CW'(1);
      b_s = CW'(mxy) + CW'(1);
      if (r_s > ws) r_s = ws;
      if (b_s > hs) b_s = hs;
      empty  = (l_s >= r_s) || (t_s >= b_s);
      left   = SW'(l_s);
      top    = SW'(t_s);
      right  = SW'(r_s);
      bottom = SW'(b_s);
   end
endmodule
`default_nettype wire

// File: rtl/core/triangle_bbox_coverage_scan.sv
// Triangle bounding-box coverage scan, top level with the sequencer.
// Depends on tbcs_pkg, tbcs_box and tbcs_mac.
//
// Usage: a req transaction with tuser = 0 starts a triangle (three vertices
// in tdata, signed with FRAC_BITS fraction bits); the block answers with one
// rsp transaction, status accepted or rejected in tuser. Each req with
// tuser = 1 then returns the next bounding-box pixel in raster order with a
// coverage flag in tdata and tlast on the final pixel; a step with no scan
// armed returns status 3. Exactly one response per request.
// Timing: one multiply-accumulate unit does all multiplications, one product
// per cycle while setup or a pixel step runs. A start runs the setup MAC steps
// and then posts the result; a step runs the pixel MAC steps, a compare step
// and then posts. A step while idle posts directly. The next request is taken
// once the sequencer has returned to idle.
// req_tready is high only while the sequencer is idle; the output register
// lets a request be taken while the previous response waits. If rsp_tready
// is low, a finished result waits in the sequencer until the output frees.
// Reset: synchronous, clears the scan and the output valid, and loads
// screen size 640 x 480. csr writes are always accepted.
`default_nettype none
module triangle_bbox_coverage_scan #(
   parameter int MAX_SCREEN = tbcs_pkg::MAX_SCREEN_DEF,
   parameter int FRAC_BITS  = tbcs_pkg::FRAC_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, zero pad
   input  wire  [87:0] req_tdata,
   // op
   input  wire  [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // pixel_x, pixel_y, covered, zero pad
   output logic [23:0] rsp_tdata,
   // status
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [0:0]  csr_index,
   input  wire  [tbcs_pkg::CSR_W-1:0] csr_data
);
   import tbcs_pkg::*;

   localparam int SW  = $clog2(MAX_SCREEN + 1);
   localparam int WXW = SW + FRAC_BITS + 2;
   localparam int CW  = ACC_W + 2;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_PIX   = 3'd2;
   localparam logic [2:0] S_PFIN  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   localparam logic [STEP_W-1:0] SETUP_LAST = STEP_W'(9);
   localparam logic [STEP_W-1:0] PIX_LAST   = STEP_W'(7);

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CSR_W-1:0]  scr_w_ff, scr_h_ff;

   logic              active_ff, active_in;
   logic [SW-1:0]     col_ff, col_in, row_ff, row_in;
   logic [SW-1:0]     left_ff, right_ff, bottom_ff, top_ff;
   logic              empty_ff;
   logic signed [VERT_W-1:0] v0x_ff, v0y_ff;
   logic signed [EDGE_W-1:0] ux_ff, uy_ff, ex_ff, ey_ff;
   logic signed [DOT_W-1:0]  dot0_ff, dot1_ff, dot2_ff;
   logic signed [DEN_W-1:0]  den_ff;
   logic signed [OPA_W-1:0]  wu_ff, wv_ff;
   logic signed [ACC_W-1:0]  ns_ff;

   logic [1:0]        pst_ff;
   logic [9:0]        px_ff, py_ff;
   logic              pcov_ff, plast_ff;

   logic              rv_ff;
   logic [1:0]        rst_ff;
   logic [9:0]        rx_ff, ry_ff;
   logic              rcov_ff, rlast_ff;

   logic signed [VERT_W-1:0] ivx0, ivy0, ivx1, ivy1, ivx2, ivy2;
   logic [SW-1:0]     b_left, b_top, b_right, b_bottom;
   logic              b_empty;

   mac_op_type        mop;
   logic              mac_en;
   logic signed [ACC_W-1:0] sum;

   logic signed [WXW-1:0] col_ext, row_ext, wx, wy;
   logic signed [CW-1:0]  d_c, ns_c, nt_c, nr_c;
   logic                  cov, lastpix, col_end, reject;
   logic                  req_acc, out_free;

   assign ivx0 = req_tdata[13:0];
   assign ivy0 = req_tdata[27:14];
   assign ivx1 = req_tdata[41:28];
   assign ivy1 = req_tdata[55:42];
   assign ivx2 = req_tdata[69:56];
   assign ivy2 = req_tdata[83:70];

   tbcs_box #(.MAX_SCREEN(MAX_SCREEN), .FRAC_BITS(FRAC_BITS)) u_box (
      .vx0(ivx0), .vy0(ivy0), .vx1(ivx1), .vy1(ivy1), .vx2(ivx2), .vy2(ivy2),
      .scr_w(scr_w_ff), .scr_h(scr_h_ff),
      .left(b_left), .top(b_top), .right(b_right), .bottom(b_bottom),
      .empty(b_empty)
   );

   tbcs_mac u_mac (
      .clock(clock), .en(mac_en), .op(mop), .sum(sum)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rv_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // pixel offset from vertex 0, in subpixel units
   always_comb begin
      col_ext = WXW'({1'b0, col_ff});
      row_ext = WXW'({1'b0, row_ff});
      wx = (col_ext <<< FRAC_BITS) - WXW'(v0x_ff);
      wy = (row_ext <<< FRAC_BITS) - WXW'(v0y_ff);
   end

   // operand schedule for the shared MAC; odd steps finish a two-term sum.
   // Outside setup and pixel steps the MAC passes its accumulator on sum.
   always_comb begin
      mop.clr = ~step_ff[0] && ((state_ff == S_SETUP) || (state_ff == S_PIX));
      mop.sub = 1'b0;
      mop.a   = '0;
      mop.b   = '0;
      if (state_ff == S_SETUP) begin
         case (step_ff)
            4'd0: begin mop.a = OPA_W'(ux_ff); mop.b = OPB_W'(ex_ff); end
            4'd1: begin mop.a = OPA_W'(uy_ff); mop.b = OPB_W'(ey_ff); end
            4'd2: begin mop.a = OPA_W'(ex_ff); mop.b = OPB_W'(ex_ff); end
            4'd3: begin mop.a = OPA_W'(ey_ff); mop.b = OPB_W'(ey_ff); end
            4'd4: begin mop.a = OPA_W'(ux_ff); mop.b = OPB_W'(ux_ff); end
            4'd5: begin mop.a = OPA_W'(uy_ff); mop.b = OPB_W'(uy_ff); end
            4'd6: begin mop.a = OPA_W'(dot0_ff); mop.b = OPB_W'(dot0_ff); end
            4'd7: begin
               mop.a = OPA_W'(dot1_ff); mop.b = OPB_W'(dot2_ff); mop.sub = 1'b1;
            end
            4'd8: begin mop.a = OPA_W'(ex_ff); mop.b = OPB_W'(uy_ff); end
            4'd9: begin
               mop.a = OPA_W'(ey_ff); mop.b = OPB_W'(ux_ff); mop.sub = 1'b1;
            end
            default: ;
         endcase
      end else begin
         case (step_ff)
            4'd0: begin mop.a = OPA_W'(wx); mop.b = OPB_W'(ux_ff); end
            4'd1: begin mop.a = OPA_W'(wy); mop.b = OPB_W'(uy_ff); end
            4'd2: begin mop.a = OPA_W'(wx); mop.b = OPB_W'(ex_ff); end
            4'd3: begin mop.a = OPA_W'(wy); mop.b = OPB_W'(ey_ff); end
            4'd4: begin mop.a = wv_ff; mop.b = OPB_W'(dot0_ff); end
            4'd5: begin mop.a = wu_ff; mop.b = OPB_W'(dot1_ff); mop.sub = 1'b1; end
            4'd6: begin mop.a = wu_ff; mop.b = OPB_W'(dot0_ff); end
            4'd7: begin mop.a = wv_ff; mop.b = OPB_W'(dot2_ff); mop.sub = 1'b1; end
            default: ;
         endcase
      end
   end

   assign mac_en = (state_ff == S_SETUP) || (state_ff == S_PIX);

   // final range tests; in PFIN sum carries the accumulator, which holds Nt
   always_comb begin
      d_c  = CW'(den_ff);
      ns_c = CW'(ns_ff);
      nt_c = CW'(sum);
      if (den_ff < 0) begin
         d_c  = -d_c;
         ns_c = -ns_c;
         nt_c = -nt_c;
      end
      nr_c = d_c - ns_c - nt_c;
      cov  = (ns_c >= 0) && (ns_c <= d_c) && (nt_c >= 0) && (nt_c <= d_c)
             && (nr_c >= 0) && (nr_c <= d_c);
      col_end = ({1'b0, col_ff} + (SW+1)'(1)) >= {1'b0, right_ff};
      lastpix = col_end && (({1'b0, row_ff} + (SW+1)'(1)) >= {1'b0, bottom_ff});
      reject  = (sum < 0) || (den_ff == 0) || empty_ff;
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      active_in = active_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               step_in = '0;
               if (req_tuser[0] == OP_START) begin
                  active_in = 1'b0;
                  state_in  = S_SETUP;
               end else if (active_ff) begin
                  state_in = S_PIX;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SETUP: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == SETUP_LAST) begin
               state_in = S_DONE;
               if (!reject) begin
                  active_in = 1'b1;
                  col_in    = left_ff;
                  row_in    = top_ff;
               end
            end
         end
         S_PIX: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == PIX_LAST) begin
               state_in = S_PFIN;
            end
         end
         S_PFIN: begin
            state_in = S_DONE;
            if (lastpix) begin
               active_in = 1'b0;
            end else if (col_end) begin
               col_in = left_ff;
               row_in = row_ff + SW'(1);
            end else begin
               col_in = col_ff + SW'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         step_ff   <= '0;
         active_ff <= 1'b0;
         rv_ff     <= 1'b0;
         scr_w_ff  <= CSR_W'(640);
         scr_h_ff  <= CSR_W'(480);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         active_ff <= active_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         if (csr_valid) begin
            unique case (csr_index[0])
               CSR_WIDTH:  scr_w_ff <= csr_data;
               CSR_HEIGHT: scr_h_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == S_DONE && out_free) begin
            rv_ff <= 1'b1;
         end else if (rsp_tready) begin
            rv_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_acc && req_tuser[0] == OP_START) begin
         v0x_ff    <= ivx0;
         v0y_ff    <= ivy0;
         ux_ff     <= EDGE_W'(ivx1) - EDGE_W'(ivx0);
         uy_ff     <= EDGE_W'(ivy1) - EDGE_W'(ivy0);
         ex_ff     <= EDGE_W'(ivx2) - EDGE_W'(ivx0);
         ey_ff     <= EDGE_W'(ivy2) - EDGE_W'(ivy0);
         left_ff   <= b_left;
         top_ff    <= b_top;
         right_ff  <= b_right;
         bottom_ff <= b_bottom;
         empty_ff  <= b_empty;
      end
      if (req_acc && req_tuser[0] == OP_STEP && !active_ff) begin
         pst_ff   <= ST_IDLE_STEP;
         px_ff    <= '0;
         py_ff    <= '0;
         pcov_ff  <= 1'b0;
         plast_ff <= 1'b0;
      end
      if (state_ff == S_SETUP) begin
         case (step_ff)
            4'd1: dot0_ff <= DOT_W'(sum);
            4'd3: dot1_ff <= DOT_W'(sum);
            4'd5: dot2_ff <= DOT_W'(sum);
            4'd7: den_ff  <= DEN_W'(sum);
            4'd9: begin
               pst_ff   <= reject ? ST_REJECT : ST_ACCEPT;
               px_ff    <= '0;
               py_ff    <= '0;
               pcov_ff  <= 1'b0;
               plast_ff <= 1'b0;
            end
            default: ;
         endcase
      end
      if (state_ff == S_PIX) begin
         case (step_ff)
            4'd1: wu_ff <= OPA_W'(sum);
            4'd3: wv_ff <= OPA_W'(sum);
            4'd5: ns_ff <= sum;
            default: ;
         endcase
      end
      if (state_ff == S_PFIN) begin
         pst_ff   <= ST_PIXEL;
         px_ff    <= 10'(col_ff);
         py_ff    <= 10'(row_ff);
         pcov_ff  <= cov;
         plast_ff <= lastpix;
      end
      if (state_ff == S_DONE && out_free) begin
         rst_ff   <= pst_ff;
         rx_ff    <= px_ff;
         ry_ff    <= py_ff;
         rcov_ff  <= pcov_ff;
         rlast_ff <= plast_ff;
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tuser  = rst_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tdata  = {3'b000, rcov_ff, ry_ff, rx_ff};

   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == ST_PIXEL))
      else $error("tlast on a non-pixel response");

   a_nonpixel_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_PIXEL) |-> (rsp_tdata == '0))
      else $error("non-pixel response carries data");

   a_scan_in_box: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (col_ff < right_ff && row_ff < bottom_ff))
      else $error("scan position outside box");

endmodule
`default_nettype wire
